FILE: hw/rtl/rrqs_pkg.sv
// Shared types and constants of the round-robin quantum scheduler.
// No dependencies.
package rrqs_pkg;

    localparam int FUNC_W = 2;
    localparam int ID_W   = 16;
    localparam int TIME_W = 20;
    localparam int KIND_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNLD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PROC = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PROC  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IDLE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNLD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL  = 3'd4;

    localparam logic REG_QUANTUM = 1'b0;
    localparam logic [TIME_W-1:0] QUANTUM_RESET = 20'd1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tm;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UNLD0,
        ST_UNLD1,
        ST_PROC0,
        ST_PROC1,
        ST_PROC2
    } state_t;

    typedef struct packed {
        logic latch;
        logic load_wr;
        logic emit_full;
        logic unld_rd;
        logic unld_emit;
        logic proc_rd;
        logic proc_admit;
        logic proc_emit;
    } cmd_t;

    typedef struct packed {
        logic wait_full;
    } status_t;

endpackage

FILE: hw/rtl/rrqs_if.sv
// Request and response channel interfaces of the scheduler.
// Depends on rrqs_pkg.
interface rrqs_req_if;
    import rrqs_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   item_id;
    logic [TIME_W-1:0] item_time;

    modport source (output valid, output func, output item_id, output item_time, input ready);
    modport sink   (input valid, input func, input item_id, input item_time, output ready);
endinterface

interface rrqs_rsp_if;
    import rrqs_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   out_id;
    logic [TIME_W-1:0] out_time;

    modport source (output valid, output kind, output out_id, output out_time, input ready);
    modport sink   (input valid, input kind, input out_id, input out_time, output ready);
endinterface

FILE: hw/rtl/rrqs_regs.sv
// APB-style configuration register: the quantum.
// Depends on rrqs_pkg.
module rrqs_regs
    import rrqs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [TIME_W-1:0] quantum
);

    logic [TIME_W-1:0] quantum_reg;
    logic [TIME_W-1:0] quantum_next;
    logic              wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && (paddr[2] == REG_QUANTUM);
    assign quantum = quantum_reg;

    always_comb
    begin
        quantum_next = quantum_reg;
        if (wr_en)
        begin
            quantum_next = pwdata[TIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            quantum_reg <= quantum_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_QUANTUM)
        begin
            prdata = {{(32-TIME_W){1'b0}}, quantum_reg};
        end
    end

endmodule

FILE: hw/rtl/rrqs_ctrl.sv
// Sequencer of the scheduler: handshakes and per-operation steps.
// Depends on rrqs_pkg; drives the datapath through cmd_t.
module rrqs_ctrl
    import rrqs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] in_func,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  status_t           status,
    output cmd_t              cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   emit;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign emit      = cmd.emit_full || cmd.unld_emit || cmd.proc_emit;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    case (in_func)
                        FUNC_LOAD: state_next = ST_LOAD;
                        FUNC_UNLD: state_next = ST_UNLD0;
                        FUNC_PROC: state_next = ST_PROC0;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (!status.wait_full)
                begin
                    cmd.load_wr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (out_free)
                begin
                    cmd.emit_full = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_UNLD0:
            begin
                cmd.unld_rd = 1'b1;
                state_next  = ST_UNLD1;
            end
            ST_UNLD1:
            begin
                if (out_free)
                begin
                    cmd.unld_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PROC0:
            begin
                cmd.proc_rd = 1'b1;
                state_next  = ST_PROC1;
            end
            ST_PROC1:
            begin
                cmd.proc_admit = 1'b1;
                state_next     = ST_PROC2;
            end
            ST_PROC2:
            begin
                if (out_free)
                begin
                    cmd.proc_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/rrqs_dp.sv
// Datapath of the scheduler: waiting FIFO, run ring, completion stack, result beat.
// Depends on rrqs_pkg; steered by cmd_t from rrqs_ctrl.
module rrqs_dp
    import rrqs_pkg::*;
#(
    parameter int ITEMS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [ID_W-1:0]   in_id,
    input  logic [TIME_W-1:0] in_time,
    input  logic [TIME_W-1:0] quantum,
    output logic [KIND_W-1:0] out_kind,
    output logic [ID_W-1:0]   out_id,
    output logic [TIME_W-1:0] out_time
);

    localparam int IW = $clog2(ITEMS);
    localparam int CW = $clog2(ITEMS + 1);
    localparam logic [CW-1:0] ITEMS_C = CW'(ITEMS);
    localparam logic [CW:0]   ITEMS_W = (CW+1)'(ITEMS);

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW+1-IW){1'b0}}, base} + {1'b0, off};
        if (sum >= ITEMS_W)
        begin
            sum = sum - ITEMS_W;
        end
        return sum[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] tail_stack_idx(input logic [CW-1:0] cnt);
        logic [CW-1:0] top;
        top = cnt - CW'(1);
        return top[IW-1:0];
    endfunction

    entry_t          wait_mem [ITEMS];
    entry_t          ring_mem [ITEMS];
    logic [ID_W-1:0] done_mem [ITEMS];

    logic [IW-1:0] wait_head_reg, wait_head_next;
    logic [CW-1:0] wait_count_reg, wait_count_next;
    logic [IW-1:0] run_head_reg, run_head_next;
    logic [CW-1:0] run_count_reg, run_count_next;
    logic [CW-1:0] stack_count_reg, stack_count_next;

    logic [ID_W-1:0]   in_id_reg;
    logic [TIME_W-1:0] in_time_reg;
    entry_t            wait_rd_reg;
    entry_t            tail_rd_reg;
    entry_t            head_rd_reg;
    logic [ID_W-1:0]   stack_rd_reg;
    logic              tail_vld_reg;
    logic              fwd_reg;
    logic              unld_ok_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] time_reg;

    logic [CW-1:0]     tail_off;
    logic              retire;
    logic              admit;
    logic [CW-1:0]     cnt1;
    logic              stack_ne;
    entry_t            head_ent;
    logic [TIME_W-1:0] slice_tm;
    logic              ring_we;
    logic [IW-1:0]     ring_wa;
    entry_t            ring_wd;

    assign status.wait_full = (wait_count_reg == ITEMS_C);
    assign out_kind = kind_reg;
    assign out_id   = id_reg;
    assign out_time = time_reg;

    assign tail_off = (run_count_reg == '0) ? '0 : run_count_reg - CW'(1);
    assign retire   = tail_vld_reg && (tail_rd_reg.tm == '0) && (stack_count_reg != ITEMS_C);
    assign cnt1     = run_count_reg - CW'(retire);
    assign admit    = (wait_count_reg != '0) && (cnt1 != ITEMS_C);
    assign stack_ne = (stack_count_reg != '0);
    assign head_ent = fwd_reg ? wait_rd_reg : head_rd_reg;
    assign slice_tm = (head_ent.tm > quantum) ? head_ent.tm - quantum : '0;

    always_comb
    begin
        ring_we = 1'b0;
        ring_wa = wrap_add(run_head_reg, cnt1);
        ring_wd = wait_rd_reg;
        if (cmd.proc_admit && admit)
        begin
            ring_we = 1'b1;
        end
        else if (cmd.proc_emit && (run_count_reg != '0))
        begin
            ring_we    = 1'b1;
            ring_wa    = wrap_add(run_head_reg, run_count_reg);
            ring_wd.id = head_ent.id;
            ring_wd.tm = slice_tm;
        end
    end

    always_comb
    begin
        wait_head_next   = wait_head_reg;
        wait_count_next  = wait_count_reg;
        run_head_next    = run_head_reg;
        run_count_next   = run_count_reg;
        stack_count_next = stack_count_reg;
        if (cmd.load_wr)
        begin
            wait_count_next = wait_count_reg + CW'(1);
        end
        if (cmd.unld_rd && stack_ne)
        begin
            stack_count_next = stack_count_reg - CW'(1);
        end
        if (cmd.proc_admit)
        begin
            stack_count_next = stack_count_reg + CW'(retire);
            run_count_next   = cnt1 + CW'(admit);
            if (admit)
            begin
                wait_head_next  = wrap_add(wait_head_reg, CW'(1));
                wait_count_next = wait_count_reg - CW'(1);
            end
        end
        if (cmd.proc_emit && (run_count_reg != '0))
        begin
            run_head_next = wrap_add(run_head_reg, CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_head_reg   <= '0;
            wait_count_reg  <= '0;
            run_head_reg    <= '0;
            run_count_reg   <= '0;
            stack_count_reg <= '0;
        end
        else
        begin
            wait_head_reg   <= wait_head_next;
            wait_count_reg  <= wait_count_next;
            run_head_reg    <= run_head_next;
            run_count_reg   <= run_count_next;
            stack_count_reg <= stack_count_next;
        end
    end

    // waiting FIFO
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            wait_mem[wrap_add(wait_head_reg, wait_count_reg)] <= '{id: in_id_reg, tm: in_time_reg};
        end
        if (cmd.proc_rd)
        begin
            wait_rd_reg <= wait_mem[wait_head_reg];
        end
    end

    // run ring: tail read, then head read alongside the admit write
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ring_wd;
        end
        if (cmd.proc_rd)
        begin
            tail_rd_reg <= ring_mem[wrap_add(run_head_reg, tail_off)];
        end
        if (cmd.proc_admit)
        begin
            head_rd_reg <= ring_mem[run_head_reg];
        end
    end

    // completion stack
    always_ff @(posedge clk)
    begin
        if (cmd.proc_admit && retire)
        begin
            done_mem[stack_count_reg[IW-1:0]] <= tail_rd_reg.id;
        end
        if (cmd.unld_rd && stack_ne)
        begin
            stack_rd_reg <= done_mem[tail_stack_idx(stack_count_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_id_reg   <= in_id;
            in_time_reg <= in_time;
        end
        if (cmd.proc_rd)
        begin
            tail_vld_reg <= (run_count_reg != '0);
        end
        if (cmd.proc_admit)
        begin
            fwd_reg <= admit && (cnt1 == '0);
        end
        if (cmd.unld_rd)
        begin
            unld_ok_reg <= stack_ne;
        end
        if (cmd.emit_full)
        begin
            kind_reg <= KIND_FULL;
            id_reg   <= '0;
            time_reg <= '0;
        end
        else if (cmd.unld_emit)
        begin
            kind_reg <= unld_ok_reg ? KIND_UNLD : KIND_EMPTY;
            id_reg   <= unld_ok_reg ? stack_rd_reg : '0;
            time_reg <= '0;
        end
        else if (cmd.proc_emit)
        begin
            if (run_count_reg == '0)
            begin
                kind_reg <= KIND_IDLE;
                id_reg   <= '0;
                time_reg <= '0;
            end
            else
            begin
                kind_reg <= KIND_PROC;
                id_reg   <= head_ent.id;
                time_reg <= slice_tm;
            end
        end
    end

endmodule

FILE: hw/rtl/round_robin_quantum_scheduler.sv
// Round-robin quantum scheduler, top level.
// LOAD, UNLD and PROC run as steps after acceptance; the run ring's single read port
// sets PROC at tail read, admit plus head read, then slice and rotate.
// Results leave through an output register; a new beat is loaded only when none waits or the waiting one is taken.
// Asynchronous active-low reset empties FIFO, ring and stack and sets quantum to 1.
// Depends on rrqs_pkg, rrqs_if, rrqs_regs, rrqs_ctrl and rrqs_dp.
module round_robin_quantum_scheduler
    import rrqs_pkg::*;
#(
    parameter int ITEMS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    rrqs_req_if.sink    req,
    rrqs_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TIME_W-1:0] quantum;
    cmd_t              cmd;
    status_t           status;

    rrqs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .quantum (quantum)
    );

    rrqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (req.func),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rrqs_dp #(
        .ITEMS (ITEMS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_id    (req.item_id),
        .in_time  (req.item_time),
        .quantum  (quantum),
        .out_kind (rsp.kind),
        .out_id   (rsp.out_id),
        .out_time (rsp.out_time)
    );

endmodule
